/* hdl/tbp_pkg.sv */
`default_nettype none

package tbp_pkg;

  // Width of a configuration register and of the write data
  localparam int CFG_W = 16;

  // Default width of the internal time base
  localparam int TIME_BITS_DEF = 32;

  // Register indexes on the configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTH_HOLD = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd50;
  localparam logic [CFG_W-1:0] HOLD_RST      = 16'd800;
  localparam logic [CFG_W-1:0] BOTH_HOLD_RST = 16'd3000;

  // Event codes
  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_FIRST_SHORT  = 3'd1,
    EV_FIRST_HOLD   = 3'd2,
    EV_SECOND_SHORT = 3'd3,
    EV_SECOND_HOLD  = 3'd4,
    EV_BOTH_HOLD    = 3'd5
  } event_t;

  // Per-button flags
  typedef struct packed {
    logic prev_level;
    logic hold_sent;
    logic release_done;
  } key_flags_t;

  // Outcome of one button check
  typedef struct packed {
    logic hit;
    logic is_hold;
  } key_res_t;

endpackage

`default_nettype wire

/* hdl/tbp_key.sv */
`default_nettype none

module tbp_key import tbp_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                 level,
  input  wire logic [TIME_BITS-1:0] now,
  input  wire logic [TIME_BITS-1:0] press_time,
  input  wire key_flags_t           flags,
  input  wire logic [CFG_W-1:0]     debounce_ms,
  input  wire logic [CFG_W-1:0]     hold_ms,
  output logic      [TIME_BITS-1:0] edge_time,
  output key_flags_t                edge_flags,
  output logic      [TIME_BITS-1:0] chk_time,
  output key_flags_t                chk_flags,
  output key_res_t                  res
);

  logic [TIME_BITS-1:0] held;
  logic                 started;
  logic                 release_go;
  logic                 hold_go;

  // Stamp the press time on a rising level and track the level
  always_comb begin
    edge_time  = press_time;
    edge_flags = flags;
    if (level && !flags.prev_level) begin
      edge_time               = now;
      edge_flags.hold_sent    = 1'b0;
      edge_flags.release_done = 1'b0;
    end
    edge_flags.prev_level = level;
  end

  // Elapsed time wraps with the time base
  assign held    = now - edge_time;
  assign started = (edge_time != '0);

  assign release_go = !level && started && !edge_flags.release_done;
  assign hold_go    = level && started && !edge_flags.hold_sent &&
                      (held >= TIME_BITS'(hold_ms));

  // Classify a release, else report a hold while still down
  always_comb begin
    chk_time    = edge_time;
    chk_flags   = edge_flags;
    res.hit     = 1'b0;
    res.is_hold = 1'b0;
    if (release_go) begin
      chk_time               = '0;
      chk_flags.release_done = 1'b1;
      if (held >= TIME_BITS'(hold_ms)) begin
        res.hit     = 1'b1;
        res.is_hold = 1'b1;
      end else if (held >= TIME_BITS'(debounce_ms)) begin
        res.hit = 1'b1;
      end
    end else if (hold_go) begin
      chk_flags.hold_sent = 1'b1;
      res.hit             = 1'b1;
      res.is_hold         = 1'b1;
    end
  end

endmodule

`default_nettype wire

/* hdl/tbp_core.sv */
`default_nettype none

module tbp_core import tbp_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 fire,
  input  wire logic [TIME_BITS-1:0] now,
  input  wire logic                 lv1,
  input  wire logic                 lv2,
  input  wire logic [CFG_W-1:0]     debounce_ms,
  input  wire logic [CFG_W-1:0]     hold_ms,
  input  wire logic [CFG_W-1:0]     both_hold_ms,
  output event_t                    ev
);

  logic [TIME_BITS-1:0] t1_r, t1_nxt, t2_r, t2_nxt, tj_r, tj_nxt;
  key_flags_t           f1_r, f1_nxt, f2_r, f2_nxt;
  logic                 js_r, js_nxt;

  logic [TIME_BITS-1:0] t1_edge, t1_chk, t2_edge, t2_chk;
  key_flags_t           f1_edge, f1_chk, f2_edge, f2_chk;
  key_res_t             r1, r2;
  logic [TIME_BITS-1:0] joint_held;

  tbp_key #(.TIME_BITS(TIME_BITS)) u_key1 (
    .level(lv1), .now(now), .press_time(t1_r), .flags(f1_r),
    .debounce_ms(debounce_ms), .hold_ms(hold_ms),
    .edge_time(t1_edge), .edge_flags(f1_edge),
    .chk_time(t1_chk), .chk_flags(f1_chk), .res(r1)
  );

  tbp_key #(.TIME_BITS(TIME_BITS)) u_key2 (
    .level(lv2), .now(now), .press_time(t2_r), .flags(f2_r),
    .debounce_ms(debounce_ms), .hold_ms(hold_ms),
    .edge_time(t2_edge), .edge_flags(f2_edge),
    .chk_time(t2_chk), .chk_flags(f2_chk), .res(r2)
  );

  assign joint_held = now - tj_r;

  // Resolve the event in priority order and form the next state
  always_comb begin
    t1_nxt = t1_edge;
    f1_nxt = f1_edge;
    t2_nxt = t2_edge;
    f2_nxt = f2_edge;
    tj_nxt = tj_r;
    js_nxt = js_r;
    ev     = EV_NONE;
    if (lv1 && lv2) begin
      if (tj_r == '0) begin
        tj_nxt = now;
        js_nxt = 1'b0;
      end else if (!js_r && (joint_held >= TIME_BITS'(both_hold_ms))) begin
        js_nxt = 1'b1;
        ev     = EV_BOTH_HOLD;
      end
    end else begin
      tj_nxt = '0;
      t1_nxt = t1_chk;
      f1_nxt = f1_chk;
      if (r1.hit) begin
        ev = r1.is_hold ? EV_FIRST_HOLD : EV_FIRST_SHORT;
      end else begin
        t2_nxt = t2_chk;
        f2_nxt = f2_chk;
        if (r2.hit) begin
          ev = r2.is_hold ? EV_SECOND_HOLD : EV_SECOND_SHORT;
        end else begin
          if (!lv1) f1_nxt.release_done = 1'b0;
          if (!lv2) f2_nxt.release_done = 1'b0;
        end
      end
    end
  end

  // Hold the button and joint state; advance once per processed poll
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r <= '0;
      t2_r <= '0;
      tj_r <= '0;
      f1_r <= '0;
      f2_r <= '0;
      js_r <= 1'b0;
    end else if (fire) begin
      t1_r <= t1_nxt;
      t2_r <= t2_nxt;
      tj_r <= tj_nxt;
      f1_r <= f1_nxt;
      f2_r <= f2_nxt;
      js_r <= js_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/two_button_press_classifier_unit.sv */
`default_nettype none

// Two-button press classifier. Each poll (timestamp plus two button levels)
// gives exactly one event code, in poll order. A poll can be taken every
// clock cycle while the result is not stalled: it lands in an input
// register, and once the result register is free one pass of compare logic
// against the per-button and joint state updates that state and loads the
// result register, so the sustained rate is one poll per cycle while
// out_stall stays low. The state update through that pass sets the rate. A
// waiting result does not block the input register; when both are full and
// the result is stalled, in_stall rises. Configuration writes take effect at
// once and belong to idle periods. There is no clearing pass after reset.
module two_button_press_classifier_unit import tbp_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [31:0]          in_now_ms,
  input  wire logic                 in_first_down,
  input  wire logic                 in_second_down,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [2:0]           out_event_res,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  logic [CFG_W-1:0]     debounce_r, hold_r, both_hold_r;
  logic                 s1_valid_r;
  logic [TIME_BITS-1:0] s1_now_r;
  logic                 s1_lv1_r, s1_lv2_r;
  logic                 out_valid_r;
  event_t               out_event_r;
  event_t               ev;
  logic                 in_take, out_take, move;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= DEBOUNCE_RST;
      hold_r      <= HOLD_RST;
      both_hold_r <= BOTH_HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE:  debounce_r  <= cfg_wdata;
        CFG_HOLD:      hold_r      <= cfg_wdata;
        CFG_BOTH_HOLD: both_hold_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: a poll moves on when the result register is empty or its result is taken
  assign out_take = out_valid_r && !out_stall;
  assign move     = s1_valid_r && (!out_valid_r || out_take);
  assign in_stall = s1_valid_r && !move;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_now_r <= TIME_BITS'(in_now_ms);
      s1_lv1_r <= in_first_down;
      s1_lv2_r <= in_second_down;
    end
  end

  tbp_core #(.TIME_BITS(TIME_BITS)) u_core (
    .clk(clk), .rst_n(rst_n), .fire(move),
    .now(s1_now_r), .lv1(s1_lv1_r), .lv2(s1_lv2_r),
    .debounce_ms(debounce_r), .hold_ms(hold_r), .both_hold_ms(both_hold_r),
    .ev(ev)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_event_r <= ev;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_event_res = out_event_r;

  // Stall only with a poll waiting in the input register
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("in_stall high with empty input register");

  // A poll that moves on always yields a result next cycle
  a_move_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_valid)
    else $error("processed poll produced no result");

  // With both buttons down only none or combined hold may come out
  a_both_down_event: assert property (@(posedge clk) disable iff (!rst_n)
    (move && s1_lv1_r && s1_lv2_r) |=>
      (out_event_res == EV_NONE || out_event_res == EV_BOTH_HOLD))
    else $error("single-button event while both buttons down");

  // A stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !move)
    else $error("result register loaded while stalled");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top import tbp_pkg::*; ();

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 12;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int PHASES          = 7;
  localparam int POLLS_PER_PHASE = 130;
  localparam int HOLD_OFF_AT     = 400;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_REPORTS     = 10;
  localparam int DIR_ROWS        = 25;
  localparam int FROM_MODEL      = -1;

  // One button as the classifier sees it
  typedef struct {
    logic        level;
    logic [31:0] press_t;
    logic        hold_sent;
    logic        rel_done;
  } button_t;

  // One directed poll; want is an event code or FROM_MODEL
  typedef struct {
    logic [31:0] now;
    logic        first;
    logic        second;
    int          want;
  } poll_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [31:0]          in_now_ms = '0;
  logic                 in_first_down = 1'b0;
  logic                 in_second_down = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           out_event_res;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DEBOUNCE;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Threshold shadows and classifier state
  logic [15:0] debounce_q = DEBOUNCE_RST;
  logic [15:0] hold_q = HOLD_RST;
  logic [15:0] both_q = BOTH_HOLD_RST;
  button_t     first_btn = '{1'b0, 32'd0, 1'b0, 1'b0};
  button_t     second_btn = '{1'b0, 32'd0, 1'b0, 1'b0};
  logic [31:0] joint_t = '0;
  logic        joint_sent = 1'b0;

  event_t      expected_events[$];
  int          mismatch_count = 0;
  int          stray_count = 0;
  int          polls_sent = 0;
  int          cycle_count = 0;
  int          seen_events[6] = '{0, 0, 0, 0, 0, 0};
  int          burst_left = 0;
  logic        hold_off_done = 1'b0;

  two_button_press_classifier_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_now_ms      (in_now_ms),
    .in_first_down  (in_first_down),
    .in_second_down (in_second_down),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_res  (out_event_res),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Latch a new press on a rising level, then track the level
  function automatic void track_level(inout button_t b, input logic lvl,
                                      input logic [31:0] now);
    if (lvl != b.level) begin
      if (lvl) begin
        b.press_t   = now;
        b.hold_sent = 1'b0;
        b.rel_done  = 1'b0;
      end
      b.level = lvl;
    end
  endfunction

  // Release first, then hold while down; a zero press time means idle
  function automatic event_t button_check(inout button_t b, input logic lvl,
                                          input logic [31:0] now,
                                          input event_t short_ev,
                                          input event_t hold_ev);
    logic [31:0] held;
    held = now - b.press_t;
    if (!lvl && b.press_t != '0 && !b.rel_done) begin
      b.rel_done = 1'b1;
      b.press_t  = '0;
      if (held >= {16'd0, hold_q}) return hold_ev;
      if (held >= {16'd0, debounce_q}) return short_ev;
    end
    if (lvl && !b.hold_sent && b.press_t != '0 && held >= {16'd0, hold_q}) begin
      b.hold_sent = 1'b1;
      return hold_ev;
    end
    return EV_NONE;
  endfunction

  // Classify one poll and advance the shadow state
  function automatic event_t classify_poll(input logic [31:0] now, input logic f,
                                           input logic s);
    event_t ev;
    track_level(first_btn, f, now);
    track_level(second_btn, s, now);
    if (f && s) begin
      if (joint_t == '0) begin
        joint_t    = now;
        joint_sent = 1'b0;
      end else if (!joint_sent && (now - joint_t) >= {16'd0, both_q}) begin
        joint_sent = 1'b1;
        return EV_BOTH_HOLD;
      end
      return EV_NONE;
    end
    joint_t = '0;
    ev = button_check(first_btn, f, now, EV_FIRST_SHORT, EV_FIRST_HOLD);
    if (ev != EV_NONE) return ev;
    ev = button_check(second_btn, s, now, EV_SECOND_SHORT, EV_SECOND_HOLD);
    if (ev != EV_NONE) return ev;
    if (!f) first_btn.rel_done = 1'b0;
    if (!s) second_btn.rel_done = 1'b0;
    return EV_NONE;
  endfunction

  // Offer one poll, wait for its transfer, queue its event, then maybe pause
  task automatic offer_poll(input logic [31:0] now, input logic f, input logic s,
                            input int want);
    event_t predicted;
    int     gap;
    in_valid       <= 1'b1;
    in_now_ms      <= now;
    in_first_down  <= f;
    in_second_down <= s;
    do @(posedge clk); while (in_stall);
    predicted = classify_poll(now, f, s);
    expected_events.push_back(want == FROM_MODEL ? predicted : event_t'(want));
    polls_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold the sender until every queued event has come back
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Check each result transfer against the oldest expected event
  always @(posedge clk) begin
    event_t want_ev;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        stray_count++;
        if (mismatch_count + stray_count <= MAX_REPORTS)
          $display("result %0d with no poll outstanding", out_event_res);
      end else begin
        want_ev = expected_events.pop_front();
        if (out_event_res <= 3'd5) seen_events[out_event_res]++;
        if (out_event_res !== want_ev) begin
          mismatch_count++;
          if (mismatch_count + stray_count <= MAX_REPORTS)
            $display("event mismatch: expected %0d (%s), got %0d", want_ev,
                     want_ev.name(), out_event_res);
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stall runs, plus one long hold-off mid-run
  initial begin : receiver
    int run_left;
    int mode;
    run_left = 0;
    mode     = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!hold_off_done && polls_sent >= HOLD_OFF_AT) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end
      if (run_left == 0) begin
        mode     = $urandom_range(0, 3);
        run_left = $urandom_range(1, 40);
      end
      run_left--;
      case (mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 7) == 0);
        end
        2: begin
          out_stall <= ($urandom_range(0, 1) == 1);
        end
        default: begin
          out_stall <= ((run_left % 8) < 5);
        end
      endcase
    end
  end

  initial begin : stimulus
    poll_row_t   dir_rows[DIR_ROWS];
    logic [15:0] phase_cfg[PHASES][3];
    logic [31:0] cur_t;
    logic [31:0] now;
    logic        lvl_f;
    logic        lvl_s;
    int          advance_ms;
    int          errors;

    // Default thresholds: debounce 50, hold 800, joint hold 3000
    dir_rows = '{
      '{32'd100,        1'b1, 1'b0, EV_NONE},
      '{32'd120,        1'b0, 1'b0, EV_NONE},        // bounce below debounce
      '{32'd200,        1'b1, 1'b0, EV_NONE},
      '{32'd260,        1'b0, 1'b0, EV_FIRST_SHORT},
      '{32'd300,        1'b0, 1'b1, EV_NONE},
      '{32'd1100,       1'b0, 1'b1, EV_SECOND_HOLD},
      '{32'd1150,       1'b0, 1'b1, EV_NONE},
      '{32'd1200,       1'b0, 1'b0, EV_SECOND_HOLD}, // hold reported again
      '{32'd0,          1'b1, 1'b0, EV_NONE},        // press stamped zero
      '{32'd5000,       1'b1, 1'b0, EV_NONE},
      '{32'd5100,       1'b0, 1'b0, EV_NONE},
      '{32'd6000,       1'b1, 1'b1, EV_NONE},
      '{32'd9000,       1'b1, 1'b1, EV_BOTH_HOLD},
      '{32'd9500,       1'b1, 1'b1, EV_NONE},
      '{32'd9600,       1'b0, 1'b1, FROM_MODEL},
      '{32'd9700,       1'b0, 1'b0, FROM_MODEL},
      '{32'd20000,      1'b1, 1'b0, FROM_MODEL},
      '{32'd20100,      1'b0, 1'b1, FROM_MODEL},     // release beats new press
      '{32'd20900,      1'b0, 1'b1, FROM_MODEL},
      '{32'hFFFF_FFF0,  1'b0, 1'b0, FROM_MODEL},
      '{32'hFFFF_FFF0,  1'b1, 1'b0, EV_NONE},
      '{32'h0000_0030,  1'b0, 1'b0, EV_FIRST_SHORT}, // across the wrap
      '{32'hFFFF_FFFF,  1'b0, 1'b1, EV_NONE},
      '{32'h0000_031F,  1'b0, 1'b1, EV_SECOND_HOLD},
      '{32'h0000_0400,  1'b0, 1'b0, FROM_MODEL}
    };
    phase_cfg = '{
      '{16'd0,     16'd0,     16'd0},
      '{16'd65535, 16'd65535, 16'd65535},
      '{16'd5,     16'd40,    16'd120},
      '{16'd0,     16'd0,     16'd0},
      '{16'd50,    16'd800,   16'd3000},
      '{16'd1,     16'd65535, 16'd0},
      '{16'd0,     16'd0,     16'd0}
    };
    for (int i = 0; i < 3; i++) begin
      phase_cfg[3][i] = 16'($urandom_range(0, 65535));
      phase_cfg[6][i] = 16'($urandom_range(0, 300));
    end

    // Reset once
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed polls under reset thresholds
    for (int i = 0; i < DIR_ROWS; i++)
      offer_poll(dir_rows[i].now, dir_rows[i].first, dir_rows[i].second,
                 dir_rows[i].want);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      // Load new thresholds while idle
      cfg_we    <= 1'b1;
      cfg_index <= CFG_DEBOUNCE;
      cfg_wdata <= phase_cfg[p][0];
      @(posedge clk);
      cfg_index <= CFG_HOLD;
      cfg_wdata <= phase_cfg[p][1];
      @(posedge clk);
      cfg_index <= CFG_BOTH_HOLD;
      cfg_wdata <= phase_cfg[p][2];
      @(posedge clk);
      cfg_we     <= 1'b0;
      debounce_q  = phase_cfg[p][0];
      hold_q      = phase_cfg[p][1];
      both_q      = phase_cfg[p][2];

      // Press sequences on a running clock, with some noise and idle stamps
      cur_t = $urandom();
      lvl_f = 1'b0;
      lvl_s = 1'b0;
      for (int n = 0; n < POLLS_PER_PHASE; n++) begin
        case ($urandom_range(0, 5))
          0: advance_ms = $urandom_range(0, 3);
          1: advance_ms = int'(debounce_q) + int'($urandom_range(0, 4)) - 2;
          2: advance_ms = int'(hold_q) + int'($urandom_range(0, 4)) - 2;
          3: advance_ms = int'(both_q) + int'($urandom_range(0, 4)) - 2;
          4: advance_ms = $urandom_range(0, int'(both_q) + int'(hold_q));
          default: advance_ms = $urandom_range(0, int'(debounce_q) + 1);
        endcase
        if (advance_ms < 0) advance_ms = 0;
        cur_t = cur_t + advance_ms;
        if ($urandom_range(0, 5) == 0) lvl_f = ~lvl_f;
        if ($urandom_range(0, 5) == 0) lvl_s = ~lvl_s;
        now = cur_t;
        case ($urandom_range(0, 99))
          0, 1, 2, 3: begin
            now   = $urandom();
            lvl_f = ($urandom_range(0, 1) == 1);
            lvl_s = ($urandom_range(0, 1) == 1);
          end
          4, 5, 6: begin
            now = '0;
          end
          default: begin
          end
        endcase
        offer_poll(now, lvl_f, lvl_s, FROM_MODEL);
      end
      drain();
    end

    errors = mismatch_count + stray_count + expected_events.size();
    $display("Sent %0d polls over %0d threshold settings plus reset values.",
             polls_sent, PHASES);
    $display("Saw %0d short, %0d single hold, %0d joint hold events; %0d errors.",
             seen_events[EV_FIRST_SHORT] + seen_events[EV_SECOND_SHORT],
             seen_events[EV_FIRST_HOLD] + seen_events[EV_SECOND_HOLD],
             seen_events[EV_BOTH_HOLD], errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/tbp_pkg.sv
hdl/tbp_key.sv
hdl/tbp_core.sv
hdl/two_button_press_classifier_unit.sv
dv/tb_top.sv
